### design/ght_pkg.sv
// ----------------------------------------------------------------------------
// Generational handle table package
// Shared constants, command codes, controller states and the command and
// status words that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none
package ght_pkg;

	localparam int NUM_SLOTS     = 1024;
	localparam int NUM_TYPES     = 32;
	localparam int MAX_QUERY_OUT = 64;
	localparam int SLOT_W        = $clog2(NUM_SLOTS);
	localparam int CNT_W         = SLOT_W + 1;
	localparam int LIM_W         = 7;
	localparam int GEN_W         = 16;
	localparam int ENTRY_W       = GEN_W + 1 + NUM_TYPES;

	localparam logic REG_IDX_TYPES = 1'b0;

	typedef enum logic [3:0] {
		CMD_CREATE   = 4'd0,
		CMD_DESTROY  = 4'd1,
		CMD_IS_ALIVE = 4'd2,
		CMD_COUNT    = 4'd3,
		CMD_ADD      = 4'd4,
		CMD_REMOVE   = 4'd5,
		CMD_HAS      = 4'd6,
		CMD_GET_MASK = 4'd7,
		CMD_QUERY    = 4'd8
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_POP,
		ST_SLOT_RD,
		ST_EXEC,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic latch;
		logic pop;
		logic exec;
		logic take;
		logic step;
		logic fin;
	} ctl_t;

	typedef struct packed {
		logic stack_nonempty;
		logic out_free;
		logic match;
		logic last_slot;
		logic limit_hit;
		logic hold_valid;
		logic scan_empty;
	} sts_t;

endpackage
`default_nettype wire

### design/ght_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module ght_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

### design/ght_ctrl.sv
// ----------------------------------------------------------------------------
// Handle table controller
// Sequences memory reads, updates, query scans and result delivery.
// ----------------------------------------------------------------------------
`default_nettype none
module ght_ctrl
	import ght_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic [3:0] cmd,
	input  wire sts_t       sts,
	output logic            in_stall,
	output ctl_t            ctl
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (cmd == CMD_QUERY) state_d = ST_SCAN_RD;
					else if (cmd == CMD_CREATE && sts.stack_nonempty) state_d = ST_POP;
					else state_d = ST_SLOT_RD;
				end
			end
			ST_POP:     state_d = ST_SLOT_RD;
			ST_SLOT_RD: state_d = ST_EXEC;
			ST_EXEC: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			ST_SCAN_RD: begin
				state_d = sts.scan_empty ? ST_FIN : ST_SCAN_CHK;
			end
			ST_SCAN_CHK: begin
				if (sts.match) begin
					if (!sts.hold_valid || sts.out_free) begin
						state_d = (sts.limit_hit || sts.last_slot) ? ST_FIN : ST_SCAN_RD;
					end
				end else begin
					state_d = sts.last_slot ? ST_FIN : ST_SCAN_RD;
				end
			end
			ST_FIN: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl      = '0;
		in_stall = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE:  ctl.latch = in_valid;
			ST_POP:   ctl.pop = 1'b1;
			ST_EXEC:  ctl.exec = sts.out_free;
			ST_SCAN_CHK: begin
				if (sts.match) begin
					if (!sts.hold_valid || sts.out_free) begin
						ctl.take = 1'b1;
						ctl.step = !(sts.limit_hit || sts.last_slot);
					end
				end else begin
					ctl.step = !sts.last_slot;
				end
			end
			ST_FIN:   ctl.fin = sts.out_free;
			default:  ctl = '0;
		endcase
	end
endmodule
`default_nettype wire

### design/ght_dp.sv
// ----------------------------------------------------------------------------
// Handle table datapath
// Slot memory, free stack, counters, query hold register and result register.
// ----------------------------------------------------------------------------
`default_nettype none
module ght_dp
	import ght_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire ctl_t        ctl,
	output sts_t             sts,
	input  wire logic [5:0]  reg_types,
	input  wire logic [3:0]  cmd,
	input  wire logic [31:0] handle,
	input  wire logic [4:0]  comp_type,
	input  wire logic [31:0] query_mask,
	input  wire logic [6:0]  query_limit,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      result_id,
	output logic             result_flag,
	output logic [31:0]      result_value,
	output logic             last
);
	logic [3:0]           cmd_q;
	logic [31:0]          id_q;
	logic [4:0]           ty_q;
	logic [31:0]          qmask_q;
	logic [LIM_W-1:0]     lim_q;
	logic [SLOT_W-1:0]    slot_q;
	logic [CNT_W-1:0]     depth_q, fresh_q, live_q;
	logic [LIM_W-1:0]     found_q;
	logic [31:0]          hold_q;
	logic                 hold_valid_q;

	logic [ENTRY_W-1:0]   ram_rdata, ram_wdata;
	logic                 ram_we;
	logic [SLOT_W-1:0]    stk_rdata;
	logic                 stk_we;

	logic                 unwritten, rd_alive, ok, full, load_out;
	logic [GEN_W-1:0]     rd_gen, gen_next;
	logic [NUM_TYPES-1:0] rd_comp, type_bit;
	logic [31:0]          ld_id, ld_value;
	logic                 ld_flag, ld_last;

	ght_ram #(.WIDTH(ENTRY_W), .DEPTH(NUM_SLOTS)) u_slots (
		.clk(clk), .we(ram_we), .waddr(slot_q), .wdata(ram_wdata),
		.raddr(slot_q), .rdata(ram_rdata)
	);

	ght_ram #(.WIDTH(SLOT_W), .DEPTH(NUM_SLOTS)) u_stack (
		.clk(clk), .we(stk_we), .waddr(depth_q[SLOT_W-1:0]), .wdata(slot_q),
		.raddr(depth_q[SLOT_W-1:0] - SLOT_W'(1)), .rdata(stk_rdata)
	);

	// Slots at or above the fresh pointer have never been written and read as cleared.
	assign unwritten = ({1'b0, slot_q} >= fresh_q);
	assign rd_gen    = unwritten ? '0 : ram_rdata[ENTRY_W-1 -: GEN_W];
	assign rd_alive  = unwritten ? 1'b0 : ram_rdata[NUM_TYPES];
	assign rd_comp   = unwritten ? '0 : ram_rdata[NUM_TYPES-1:0];
	assign ok        = (id_q[15:0] != 16'd0) && (id_q[15:SLOT_W] == '0) && rd_alive
		&& (rd_gen == id_q[31:16]);
	assign type_bit  = NUM_TYPES'(1) << ty_q;
	assign full      = (depth_q == '0) && (fresh_q == CNT_W'(NUM_SLOTS));
	assign gen_next  = ((rd_gen + GEN_W'(1)) == '0) ? GEN_W'(1) : rd_gen + GEN_W'(1);

	always_comb begin
		ram_we    = 1'b0;
		ram_wdata = {rd_gen, rd_alive, rd_comp};
		stk_we    = 1'b0;
		ld_id     = '0;
		ld_flag   = 1'b0;
		ld_value  = '0;
		ld_last   = 1'b1;
		if (ctl.exec) begin
			case (cmd_q)
				CMD_CREATE: begin
					if (!full) begin
						ram_we    = 1'b1;
						ram_wdata = {gen_next, 1'b1, {NUM_TYPES{1'b0}}};
						ld_id     = {gen_next, 16'(slot_q)};
					end
				end
				CMD_DESTROY: begin
					if (ok) begin
						ram_we    = 1'b1;
						ram_wdata = {rd_gen, 1'b0, {NUM_TYPES{1'b0}}};
						stk_we    = (depth_q < CNT_W'(NUM_SLOTS));
					end
				end
				CMD_IS_ALIVE: ld_flag = ok;
				CMD_COUNT:    ld_value = 32'(live_q);
				CMD_ADD: begin
					if (ok && ({1'b0, ty_q} < reg_types)) begin
						ram_we    = 1'b1;
						ram_wdata = {rd_gen, rd_alive, rd_comp | type_bit};
					end
				end
				CMD_REMOVE: begin
					if (ok) begin
						ram_we    = 1'b1;
						ram_wdata = {rd_gen, rd_alive, rd_comp & ~type_bit};
					end
				end
				CMD_HAS:      ld_flag = ok && ((rd_comp & type_bit) != '0);
				CMD_GET_MASK: ld_value = ok ? 32'(rd_comp) : 32'd0;
				default:      ld_last = 1'b1;
			endcase
		end else if (ctl.fin) begin
			ld_id    = hold_valid_q ? hold_q : 32'd0;
			ld_value = hold_valid_q ? 32'(found_q) : 32'd0;
		end else begin
			ld_id   = hold_q;
			ld_last = 1'b0;
		end
	end

	assign load_out = ctl.exec || ctl.fin || (ctl.take && hold_valid_q);

	assign sts.stack_nonempty = (depth_q != '0);
	assign sts.out_free       = !out_valid || !out_stall;
	assign sts.match          = rd_alive && ((rd_comp & qmask_q) == qmask_q);
	assign sts.last_slot      = (({1'b0, slot_q} + CNT_W'(1)) == fresh_q);
	assign sts.limit_hit      = ((found_q + LIM_W'(1)) == lim_q);
	assign sts.hold_valid     = hold_valid_q;
	assign sts.scan_empty     = (lim_q == '0) || (fresh_q == CNT_W'(1));

	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			cmd_q   <= cmd;
			id_q    <= handle;
			ty_q    <= comp_type;
			qmask_q <= query_mask;
			lim_q   <= (query_limit > LIM_W'(MAX_QUERY_OUT)) ? LIM_W'(MAX_QUERY_OUT)
				: query_limit;
			if (cmd == CMD_QUERY) slot_q <= SLOT_W'(1);
			else if (cmd == CMD_CREATE) slot_q <= fresh_q[SLOT_W-1:0];
			else slot_q <= handle[SLOT_W-1:0];
		end else if (ctl.pop) begin
			slot_q <= stk_rdata;
		end else if (ctl.step) begin
			slot_q <= slot_q + SLOT_W'(1);
		end
		if (ctl.take) begin
			hold_q <= {rd_gen, 16'(slot_q)};
		end
		if (load_out) begin
			result_id    <= ld_id;
			result_flag  <= ld_flag;
			result_value <= ld_value;
			last         <= ld_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q      <= '0;
			fresh_q      <= CNT_W'(1);
			live_q       <= '0;
			found_q      <= '0;
			hold_valid_q <= 1'b0;
			out_valid    <= 1'b0;
		end else begin
			if (ctl.exec && cmd_q == CMD_CREATE && !full) begin
				live_q <= live_q + CNT_W'(1);
				if (depth_q != '0) depth_q <= depth_q - CNT_W'(1);
				else fresh_q <= fresh_q + CNT_W'(1);
			end
			if (ctl.exec && cmd_q == CMD_DESTROY && ok) begin
				live_q <= live_q - CNT_W'(1);
				if (stk_we) depth_q <= depth_q + CNT_W'(1);
			end
			if (ctl.latch || ctl.fin) begin
				found_q      <= '0;
				hold_valid_q <= 1'b0;
			end else if (ctl.take) begin
				found_q      <= found_q + LIM_W'(1);
				hold_valid_q <= 1'b1;
			end
			if (load_out) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
		end
	end
endmodule
`default_nettype wire

### design/generational_handle_table_unit.sv
// ----------------------------------------------------------------------------
// Generational handle table unit
// Allocates and checks generational handles over a table of 1024 slots.
// ----------------------------------------------------------------------------
// One word is worked on at a time. A create reads the slot memory; when it
// reuses a freed slot, the free stack read comes before the slot memory read.
// Other single commands wait for the slot memory read and its registered data.
// A query reads and checks the ever allocated slots in turn until its result
// limit is hit, and takes longer while results are stalled. The slot store
// needs no clearing after reset: slots beyond the highest ever allocated
// read as cleared.
`default_nettype none
module generational_handle_table_unit
	import ght_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [3:0]  cmd,
	input  wire logic [31:0] handle,
	input  wire logic [4:0]  comp_type,
	input  wire logic [31:0] query_mask,
	input  wire logic [6:0]  query_limit,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      result_id,
	output logic             result_flag,
	output logic [31:0]      result_value,
	output logic             last
);
	logic [5:0] reg_types_q;
	ctl_t       ctl;
	sts_t       sts;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_IDX_TYPES) ? {26'd0, reg_types_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg_types_q <= '0;
		end else if (psel && penable && pwrite && paddr[2] == REG_IDX_TYPES) begin
			reg_types_q <= pwdata[5:0];
		end
	end

	ght_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .cmd(cmd),
		.sts(sts), .in_stall(in_stall), .ctl(ctl)
	);

	ght_dp u_dp (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .sts(sts), .reg_types(reg_types_q),
		.cmd(cmd), .handle(handle), .comp_type(comp_type),
		.query_mask(query_mask), .query_limit(query_limit),
		.out_valid(out_valid), .out_stall(out_stall), .result_id(result_id),
		.result_flag(result_flag), .result_value(result_value), .last(last)
	);
endmodule
`default_nettype wire
